### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the design files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define CAU_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define CAU_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CAU_ASSERT_IMPL(name, clk, rst, ante, cons, msg)
`define CAU_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif
`endif

### design/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Operation codes and internal mode codes of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int OP_BITS = 3;

   // operation field of the request word
   typedef enum logic [OP_BITS-1:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_NEG = 3'd4
   } cau_op_type;

   // how the back end finishes a word
   typedef enum logic [1:0] {
      MODE_PASS,
      MODE_ROUND,
      MODE_DIV
   } cau_mode_type;

endpackage

### design/cau_req_if.sv
// ----------------------------------------------------------------------------
// cau_req_if
// Request channel: operation and two complex operands, valid/ready.
// ----------------------------------------------------------------------------
interface cau_req_if #(parameter int WORD_BITS = 32);
   import cau_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [OP_BITS-1:0]          operation;
   logic signed [WORD_BITS-1:0] a_re;
   logic signed [WORD_BITS-1:0] a_im;
   logic signed [WORD_BITS-1:0] b_re;
   logic signed [WORD_BITS-1:0] b_im;

   modport source (output valid, operation, a_re, a_im, b_re, b_im, input ready);
   modport sink   (input valid, operation, a_re, a_im, b_re, b_im, output ready);
endinterface

### design/cau_rsp_if.sv
// ----------------------------------------------------------------------------
// cau_rsp_if
// Response channel: complex result and status flags, valid/ready.
// ----------------------------------------------------------------------------
interface cau_rsp_if #(parameter int WORD_BITS = 32);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] res_re;
   logic signed [WORD_BITS-1:0] res_im;
   logic                        div_by_zero;
   logic                        overflow;

   modport source (output valid, res_re, res_im, div_by_zero, overflow, input ready);
   modport sink   (input valid, res_re, res_im, div_by_zero, overflow, output ready);
endinterface

### design/cau_prod.sv
// ----------------------------------------------------------------------------
// cau_prod
// Front end: input skid word, operand register, product stage and sum stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cau_prod #(
   parameter int WORD_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   cau_req_if.sink                         req_chan,
   input  logic                            adv,
   output logic                            c_valid,
   output cau_pkg::cau_mode_type           c_mode,
   output logic signed [2*WORD_BITS:0]     c_re,
   output logic signed [2*WORD_BITS:0]     c_im,
   output logic [2*WORD_BITS-1:0]          c_den
);
   import cau_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int DW = 2 * W;
   localparam int SW = 2 * W + 1;

   typedef struct packed {
      logic [OP_BITS-1:0] op;
      logic signed [W-1:0] ar;
      logic signed [W-1:0] ai;
      logic signed [W-1:0] br;
      logic signed [W-1:0] bi;
   } item_type;

   typedef struct packed {
      logic [OP_BITS-1:0]   op;
      logic signed [W-1:0]  ar;
      logic signed [W-1:0]  ai;
      logic signed [W-1:0]  br;
      logic signed [W-1:0]  bi;
      logic signed [DW-1:0] p_rr;
      logic signed [DW-1:0] p_ii;
      logic signed [DW-1:0] p_ri;
      logic signed [DW-1:0] p_ir;
      logic signed [DW-1:0] q_rr;
      logic signed [DW-1:0] q_ii;
   } prod_type;

   logic         req_fire;
   item_type     req_item;
   logic         skid_v_ff, skid_v_in;
   item_type     skid_ff;
   logic         a_v_ff, a_v_in;
   item_type     a_ff;
   logic         b_v_ff, b_v_in;
   prod_type     b_ff, b_in;
   logic         c_v_ff, c_v_in;
   cau_mode_type c_mode_ff, c_mode_in;
   logic signed [SW-1:0] c_re_ff, c_re_in, c_im_ff, c_im_in;
   logic [DW-1:0] c_den_ff, c_den_in;
   logic signed [SW-1:0] ar_x, ai_x, br_x, bi_x;

   // request side: skid word absorbs one word while the pipe is held
   assign req_chan.ready = !skid_v_ff;
   assign req_fire       = req_chan.valid && !skid_v_ff;
   assign req_item       = '{op: req_chan.operation, ar: req_chan.a_re, ai: req_chan.a_im,
                             br: req_chan.b_re, bi: req_chan.b_im};

   always_comb begin
      skid_v_in = skid_v_ff ? !adv : (req_fire && !adv);
      a_v_in    = adv ? (skid_v_ff || req_fire) : a_v_ff;
      b_v_in    = adv ? a_v_ff : b_v_ff;
      c_v_in    = adv ? b_v_ff : c_v_ff;
   end

   // products
   always_comb begin
      b_in.op   = a_ff.op;
      b_in.ar   = a_ff.ar;
      b_in.ai   = a_ff.ai;
      b_in.br   = a_ff.br;
      b_in.bi   = a_ff.bi;
      b_in.p_rr = a_ff.ar * a_ff.br;
      b_in.p_ii = a_ff.ai * a_ff.bi;
      b_in.p_ri = a_ff.ar * a_ff.bi;
      b_in.p_ir = a_ff.ai * a_ff.br;
      b_in.q_rr = a_ff.br * a_ff.br;
      b_in.q_ii = a_ff.bi * a_ff.bi;
   end

   // exact sums per operation, divisor norm
   always_comb begin
      ar_x      = SW'(b_ff.ar);
      ai_x      = SW'(b_ff.ai);
      br_x      = SW'(b_ff.br);
      bi_x      = SW'(b_ff.bi);
      c_den_in  = DW'($unsigned(b_ff.q_rr)) + DW'($unsigned(b_ff.q_ii));
      c_mode_in = MODE_PASS;
      case (b_ff.op)
         OP_ADD: begin
            c_re_in = ar_x + br_x;
            c_im_in = ai_x + bi_x;
         end
         OP_SUB: begin
            c_re_in = ar_x - br_x;
            c_im_in = ai_x - bi_x;
         end
         OP_MUL: begin
            c_re_in   = SW'(b_ff.p_rr) - SW'(b_ff.p_ii);
            c_im_in   = SW'(b_ff.p_ri) + SW'(b_ff.p_ir);
            c_mode_in = MODE_ROUND;
         end
         OP_DIV: begin
            c_re_in   = SW'(b_ff.p_rr) + SW'(b_ff.p_ii);
            c_im_in   = SW'(b_ff.p_ir) - SW'(b_ff.p_ri);
            c_mode_in = MODE_DIV;
         end
         OP_NEG: begin
            c_re_in = -br_x;
            c_im_in = -bi_x;
         end
         default: begin
            c_re_in = '0;
            c_im_in = '0;
         end
      endcase
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
         a_v_ff    <= 1'b0;
         b_v_ff    <= 1'b0;
         c_v_ff    <= 1'b0;
      end else begin
         skid_v_ff <= skid_v_in;
         a_v_ff    <= a_v_in;
         b_v_ff    <= b_v_in;
         c_v_ff    <= c_v_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_fire && !adv) begin
         skid_ff <= req_item;
      end
      if (adv) begin
         a_ff      <= skid_v_ff ? skid_ff : req_item;
         b_ff      <= b_in;
         c_mode_ff <= c_mode_in;
         c_re_ff   <= c_re_in;
         c_im_ff   <= c_im_in;
         c_den_ff  <= c_den_in;
      end
   end

   assign c_valid = c_v_ff;
   assign c_mode  = c_mode_ff;
   assign c_re    = c_re_ff;
   assign c_im    = c_im_ff;
   assign c_den   = c_den_ff;

   // the skid word fills only while the pipe is held
   `CAU_ASSERT_IMPL(a_skid_fill, clock, reset, skid_v_ff && !$past(skid_v_ff), !$past(adv), "skid filled while pipe advanced")

endmodule

### design/cau_div.sv
// ----------------------------------------------------------------------------
// cau_div
// Back end: magnitude, rounding or dividend setup, range check, one quotient
// bit per stage, then saturation into the response register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cau_div #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        c_valid,
   input  cau_pkg::cau_mode_type       c_mode,
   input  logic signed [2*WORD_BITS:0] c_re,
   input  logic signed [2*WORD_BITS:0] c_im,
   input  logic [2*WORD_BITS-1:0]      c_den,
   output logic                        adv,
   cau_rsp_if.source                   rsp_chan
);
   import cau_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int DW = 2 * W;
   localparam int SW = 2 * W + 1;
   localparam int NW = 2 * W + F + 2;
   localparam int XW = NW + W;
   localparam int NS = W + 4;
   localparam logic [SW-1:0] HALF    = SW'(1) << (F - 1);
   localparam logic [SW-1:0] LIM_NEG = SW'(1) << (W - 1);
   localparam logic [SW-1:0] LIM_POS = LIM_NEG - SW'(1);

   typedef struct packed {
      cau_mode_type  mode;
      logic          dz;
      logic          neg_re;
      logic          neg_im;
      logic [SW-1:0] mag_re;
      logic [SW-1:0] mag_im;
      logic [DW-1:0] den;
   } mag_type;

   typedef struct packed {
      cau_mode_type  mode;
      logic          dz;
      logic          neg_re;
      logic          neg_im;
      logic [SW-1:0] mag_re;
      logic [SW-1:0] mag_im;
      logic [NW-1:0] num_re;
      logic [NW-1:0] num_im;
      logic [DW:0]   den2;
   } num_type;

   typedef struct packed {
      cau_mode_type  mode;
      logic          dz;
      logic          neg_re;
      logic          neg_im;
      logic [SW-1:0] mag_re;
      logic [SW-1:0] mag_im;
      logic [NW-1:0] rem_re;
      logic [NW-1:0] rem_im;
      logic [W-1:0]  q_re;
      logic [W-1:0]  q_im;
      logic          qo_re;
      logic          qo_im;
      logic [DW:0]   den2;
   } quo_type;

   typedef struct packed {
      logic         ovf;
      logic [W-1:0] val;
   } sat_type;

   logic [NS-1:0] v_ff, v_in;
   mag_type       m_ff, m_in;
   num_type       n_ff, n_in;
   quo_type       q_ff [W+1];
   quo_type       q_in [W+1];
   logic [W-1:0]  o_re_ff, o_re_in, o_im_ff, o_im_in;
   logic          o_dz_ff, o_dz_in, o_ovf_ff, o_ovf_in;
   logic [SW-1:0] f_mag_re, f_mag_im;
   sat_type       s_re, s_im;

   // clamp a sign/magnitude value to the word range
   function automatic sat_type saturate(input logic neg, input logic [SW-1:0] mag,
                                        input logic clip);
      logic [SW-1:0] lim;
      logic [SW-1:0] m;
      logic [SW-1:0] t;
      sat_type       r;
      lim   = neg ? LIM_NEG : LIM_POS;
      m     = mag;
      r.ovf = 1'b0;
      if (clip || mag > lim) begin
         m     = lim;
         r.ovf = 1'b1;
      end
      t     = neg ? (~m + SW'(1)) : m;
      r.val = t[W-1:0];
      return r;
   endfunction

   // whole pipe moves unless the response word is held
   assign adv  = !v_ff[NS-1] || rsp_chan.ready;
   assign v_in = adv ? {v_ff[NS-2:0], c_valid} : v_ff;

   // sign/magnitude, zero divisor
   always_comb begin
      m_in.mode   = c_mode;
      m_in.dz     = 1'b0;
      m_in.neg_re = c_re[SW-1];
      m_in.neg_im = c_im[SW-1];
      m_in.mag_re = c_re[SW-1] ? $unsigned(-c_re) : $unsigned(c_re);
      m_in.mag_im = c_im[SW-1] ? $unsigned(-c_im) : $unsigned(c_im);
      m_in.den    = c_den;
      if (c_mode == MODE_DIV && c_den == '0) begin
         m_in.mode   = MODE_PASS;
         m_in.dz     = 1'b1;
         m_in.neg_re = 1'b0;
         m_in.neg_im = 1'b0;
         m_in.mag_re = '0;
         m_in.mag_im = '0;
      end
   end

   // product rounding, dividend N*2^(F+1)+D over 2D
   always_comb begin
      n_in.mode   = m_ff.mode;
      n_in.dz     = m_ff.dz;
      n_in.neg_re = m_ff.neg_re;
      n_in.neg_im = m_ff.neg_im;
      n_in.mag_re = m_ff.mag_re;
      n_in.mag_im = m_ff.mag_im;
      if (m_ff.mode == MODE_ROUND) begin
         n_in.mag_re = (m_ff.mag_re + HALF) >> F;
         n_in.mag_im = (m_ff.mag_im + HALF) >> F;
      end
      n_in.num_re = (NW'(m_ff.mag_re) << (F + 1)) + NW'(m_ff.den);
      n_in.num_im = (NW'(m_ff.mag_im) << (F + 1)) + NW'(m_ff.den);
      n_in.den2   = {m_ff.den, 1'b0};
   end

   // quotient at or above 2^W saturates anyway
   always_comb begin
      q_in[0].mode   = n_ff.mode;
      q_in[0].dz     = n_ff.dz;
      q_in[0].neg_re = n_ff.neg_re;
      q_in[0].neg_im = n_ff.neg_im;
      q_in[0].mag_re = n_ff.mag_re;
      q_in[0].mag_im = n_ff.mag_im;
      q_in[0].rem_re = n_ff.num_re;
      q_in[0].rem_im = n_ff.num_im;
      q_in[0].q_re   = '0;
      q_in[0].q_im   = '0;
      q_in[0].qo_re  = XW'(n_ff.num_re) >= (XW'(n_ff.den2) << W);
      q_in[0].qo_im  = XW'(n_ff.num_im) >= (XW'(n_ff.den2) << W);
      q_in[0].den2   = n_ff.den2;
   end

   // restoring division, one quotient bit per stage, msb first
   for (genvar j = 0; j < W; j++) begin : g_bit
      logic [XW-1:0] den_sh;
      logic [XW:0]   diff_re;
      logic [XW:0]   diff_im;
      always_comb begin
         den_sh  = XW'(q_ff[j].den2) << (W - 1 - j);
         diff_re = {1'b0, XW'(q_ff[j].rem_re)} - {1'b0, den_sh};
         diff_im = {1'b0, XW'(q_ff[j].rem_im)} - {1'b0, den_sh};
         q_in[j+1] = q_ff[j];
         if (!diff_re[XW]) begin
            q_in[j+1].rem_re        = diff_re[NW-1:0];
            q_in[j+1].q_re[W-1-j]   = 1'b1;
         end
         if (!diff_im[XW]) begin
            q_in[j+1].rem_im        = diff_im[NW-1:0];
            q_in[j+1].q_im[W-1-j]   = 1'b1;
         end
      end
   end

   // saturation into the response word
   always_comb begin
      f_mag_re = (q_ff[W].mode == MODE_DIV) ? SW'(q_ff[W].q_re) : q_ff[W].mag_re;
      f_mag_im = (q_ff[W].mode == MODE_DIV) ? SW'(q_ff[W].q_im) : q_ff[W].mag_im;
      s_re     = saturate(q_ff[W].neg_re, f_mag_re,
                          (q_ff[W].mode == MODE_DIV) && q_ff[W].qo_re);
      s_im     = saturate(q_ff[W].neg_im, f_mag_im,
                          (q_ff[W].mode == MODE_DIV) && q_ff[W].qo_im);
      o_re_in  = s_re.val;
      o_im_in  = s_im.val;
      o_dz_in  = q_ff[W].dz;
      o_ovf_in = s_re.ovf || s_im.ovf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff     <= m_in;
         n_ff     <= n_in;
         for (int k = 0; k <= W; k++) begin
            q_ff[k] <= q_in[k];
         end
         o_re_ff  <= o_re_in;
         o_im_ff  <= o_im_in;
         o_dz_ff  <= o_dz_in;
         o_ovf_ff <= o_ovf_in;
      end
   end

   assign rsp_chan.valid       = v_ff[NS-1];
   assign rsp_chan.res_re      = o_re_ff;
   assign rsp_chan.res_im      = o_im_ff;
   assign rsp_chan.div_by_zero = o_dz_ff;
   assign rsp_chan.overflow    = o_ovf_ff;

   `CAU_ASSERT_IMPL(a_dz_zero, clock, reset, v_ff[NS-1] && o_dz_ff, o_re_ff == '0 && o_im_ff == '0 && !o_ovf_ff, "zero divisor word not cleared")
   `CAU_ASSERT_NEXT(a_hold, clock, reset, !adv, v_ff[NS-1] && $stable(o_re_ff) && $stable(o_im_ff), "held response word changed")
   `CAU_ASSERT_NEXT(a_flow, clock, reset, adv && v_ff[0], v_ff[1], "word lost between stages")

endmodule

### design/complex_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core
// Pipelined complex add, subtract, multiply, divide and negate on signed
// fixed-point words, with saturation and divide-by-zero flag.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries operation, a_re, a_im, b_re, b_im; rsp_chan carries
//   res_re, res_im, div_by_zero, overflow. Both are valid/ready channels; a
//   word moves on a clock edge where valid and ready are both high.
//   Throughput is one word per cycle while rsp_chan is not stalled. Every
//   operation takes the same path from request to response, through the
//   quotient pipeline with one bit per stage.
//   Responses come back in request order.
//   When rsp_chan is stalled the whole pipeline holds; one more request word
//   is still taken into a skid register, after which req_chan.ready drops
//   until the pipeline moves again.
//   Reset (synchronous, active high) empties the pipeline and the skid
//   register; no configuration is needed.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_core #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   cau_req_if.sink   req_chan,
   cau_rsp_if.source rsp_chan
);
   import cau_pkg::*;

   logic                        adv;
   logic                        c_valid;
   cau_mode_type                c_mode;
   logic signed [2*WORD_BITS:0] c_re;
   logic signed [2*WORD_BITS:0] c_im;
   logic [2*WORD_BITS-1:0]      c_den;

   // products and exact sums
   cau_prod #(.WORD_BITS(WORD_BITS)) u_prod (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .adv      (adv),
      .c_valid  (c_valid),
      .c_mode   (c_mode),
      .c_re     (c_re),
      .c_im     (c_im),
      .c_den    (c_den)
   );

   // rounding, division and saturation
   cau_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .c_valid  (c_valid),
      .c_mode   (c_mode),
      .c_re     (c_re),
      .c_im     (c_im),
      .c_den    (c_den),
      .adv      (adv),
      .rsp_chan (rsp_chan)
   );

endmodule
